### hdl/sparse_int_scalar_arith_assert.svh
// Assertion macros shared by the arithmetic block.
`ifndef SPARSE_INT_SCALAR_ARITH_ASSERT_SVH
`define SPARSE_INT_SCALAR_ARITH_ASSERT_SVH

// Checks that a condition implies a consequence in the same cycle.
`define SISA_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Checks that a condition implies a consequence in the next cycle.
`define SISA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hdl/sisa_pkg.sv
package sisa_pkg;

  localparam int unsigned OpW  = 3;
  localparam int unsigned ValW = 32;
  localparam int unsigned OffW = 31;
  localparam int unsigned QW   = 33;

  // Division cells, one quotient bit each; the entry and exit cells are extra.
  localparam int unsigned NumCells = QW;

  localparam logic [OpW-1:0] OP_ADD = 3'd0;
  localparam logic [OpW-1:0] OP_SUB = 3'd1;
  localparam logic [OpW-1:0] OP_MUL = 3'd2;
  localparam logic [OpW-1:0] OP_MOD = 3'd3;
  localparam logic [OpW-1:0] OP_DIV = 3'd4;

  localparam logic [ValW-1:0] NaVal = 32'h8000_0000;

  localparam logic CfgIdxOp  = 1'b0;
  localparam logic CfgIdxScl = 1'b1;

  // Item state carried from cell to cell.
  typedef struct packed {
    logic              vld;
    logic [OffW-1:0]   offset;
    logic              last;
    logic [OpW-1:0]    op;
    logic              special;   // result already settled (NA or add/sub/mul)
    logic [ValW-1:0]   sres;      // settled result
    logic              sovf;
    logic              xneg;
    logic              yneg;
    logic [QW-1:0]     rem;       // partial remainder magnitude
    logic [QW-1:0]     dvd;       // dividend bits shifting in / quotient out
    logic [ValW:0]     dsr;       // divisor magnitude
  } sisa_item_t;

endpackage

### hdl/sparse_int_scalar_arith.sv
// Sparse integer vector add/sub/mul/mod/div by scalar, one element per item.
// Input channel s_axis: tdata carries the element offset and value, tlast
// marks the last element of the vector. Output channel m_axis: tdata carries
// offset, value, keep and overflow flags, tlast copies the input marker.
// The operation and scalar are written through cfg_we_i/cfg_idx_i/cfg_data_i
// (index 0 operation code, index 1 scalar); the user must write them only
// while the block is idle, as the block itself does not enforce this. An
// accepted input passes an entry cell with the 32x32 multiplier, 33 division
// cells giving one quotient bit each, and an output cell that applies the
// floored sign fixes. The chain takes one item per cycle unless stalled.
// When the receiver stalls, the whole chain holds and s_axis_tready drops
// unless the output register is empty, so no item is lost.
// Reset empties the chain and sets operation add and scalar zero.
module sparse_int_scalar_arith
  import sisa_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [63:0]  s_axis_tdata,  // elem_offset[30:0], elem_value[62:31], 0
  input  logic         s_axis_tlast,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [71:0]  m_axis_tdata,  // out_offset[30:0], out_value[62:31],
                                      // keep[63], overflowed[64], 0
  output logic         m_axis_tlast,
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [31:0]  cfg_data_i
);

  logic [OpW-1:0]  op_q;
  logic [ValW-1:0] scl_q;
  logic en;
  sisa_item_t chain [NumCells+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q  <= OP_ADD;
      scl_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgIdxOp:  op_q  <= cfg_data_i[OpW-1:0];
        CfgIdxScl: scl_q <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  logic out_vld_q;
  logic [71:0] out_data_q;
  logic out_last_q;

  assign en = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  sisa_front u_front (
    .clk_i, .rst_ni, .en_i(en),
    .vld_i(s_axis_tvalid),
    .offset_i(s_axis_tdata[OffW-1:0]),
    .value_i(s_axis_tdata[OffW+ValW-1:OffW]),
    .last_i(s_axis_tlast),
    .op_i(op_q), .scalar_i(scl_q),
    .item_o(chain[0])
  );

  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    sisa_div_cell u_cell (
      .clk_i, .rst_ni, .en_i(en), .prev_i(chain[g]), .item_o(chain[g+1])
    );
  end

  sisa_item_t t;
  logic [QW-1:0] q, qf, rm;
  logic [ValW-1:0] res;
  logic inexact;

  // Output cell: sign the truncated quotient and remainder, then floor.
  always_comb begin
    t = chain[NumCells];
    inexact = t.rem != '0;
    q  = (t.xneg ^ t.yneg) ? QW'(-t.dvd) : t.dvd;
    qf = (inexact && (t.xneg ^ t.yneg)) ? q - QW'(1) : q;
    rm = t.xneg ? QW'(-t.rem) : t.rem;
    if (inexact && (t.xneg ^ t.yneg)) rm = rm + {t.dsr[ValW-1] & 1'b0, t.yneg ?
      ValW'(-t.dsr[ValW-1:0]) : t.dsr[ValW-1:0]};
    if (t.special) res = t.sres;
    else if (t.op == OP_DIV) res = qf[ValW-1:0];
    else res = rm[ValW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= t.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= {7'd0, t.special & t.sovf, res != '0, res, t.offset};
      out_last_q <= t.last;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

`include "sparse_int_scalar_arith_assert.svh"

  `SISA_ASSERT_IMPL(a_ovf_na, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[64],
    m_axis_tdata[62:31] == NaVal)
  `SISA_ASSERT_IMPL(a_keep, clk_i, rst_ni, m_axis_tvalid,
    m_axis_tdata[63] == (m_axis_tdata[62:31] != '0))
  `SISA_ASSERT_NEXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata))

endmodule

### hdl/sisa_div_cell.sv
module sisa_div_cell
  import sisa_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  sisa_item_t prev_i,
  output sisa_item_t item_o
);

  sisa_item_t item_d, item_q;
  logic [QW:0] trial;
  logic [QW-1:0] shifted;

  // One restoring-division step: shift in the next dividend bit, try a subtract.
  always_comb begin
    item_d = prev_i;
    shifted = {prev_i.rem[QW-2:0], prev_i.dvd[QW-1]};
    trial = {1'b0, shifted} - {{(QW-ValW){1'b0}}, prev_i.dsr};
    item_d.dvd = {prev_i.dvd[QW-2:0], ~trial[QW]};
    item_d.rem = trial[QW] ? shifted : trial[QW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q <= '0;
    end else if (en_i) begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

endmodule

### hdl/sisa_front.sv
module sisa_front
  import sisa_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [OffW-1:0]   offset_i,
  input  logic [ValW-1:0]   value_i,
  input  logic              last_i,
  input  logic [OpW-1:0]    op_i,
  input  logic [ValW-1:0]   scalar_i,
  output sisa_item_t        item_o
);

  sisa_item_t item_d, item_q;
  logic signed [ValW-1:0] x, y;
  logic signed [2*ValW-1:0] prod;
  logic signed [ValW+1:0] sum;
  logic signed [2*ValW-1:0] wide;
  logic is_arith;

  // Entry cell: settles add/sub/mul, NA, zero divisor and bad ops; sets up div.
  always_comb begin
    x = signed'(value_i);
    y = signed'(scalar_i);
    prod = x * y;
    sum = '0;
    is_arith = 1'b1;
    unique case (op_i)
      OP_ADD:  sum = {{2{x[ValW-1]}}, x} + {{2{y[ValW-1]}}, y};
      OP_SUB:  sum = {{2{x[ValW-1]}}, x} - {{2{y[ValW-1]}}, y};
      default: is_arith = 1'b0;
    endcase
    wide = (op_i == OP_MUL) ? prod : {{(2*ValW-ValW-2){sum[ValW+1]}}, sum};
    item_d = '0;
    item_d.vld    = vld_i;
    item_d.offset = offset_i;
    item_d.last   = last_i;
    item_d.op     = op_i;
    item_d.xneg   = x[ValW-1];
    item_d.yneg   = y[ValW-1];
    item_d.dsr    = {1'b0, y[ValW-1] ? ValW'(-y) : y};
    item_d.dvd    = {1'b0, x[ValW-1] ? ValW'(-x) : x};
    item_d.special = 1'b1;
    item_d.sres    = NaVal;
    if (value_i == NaVal || scalar_i == NaVal) begin
      item_d.sres = NaVal;
    end else if (is_arith || op_i == OP_MUL) begin
      if (wide <= -64'sd2147483648 || wide > 64'sd2147483647) begin
        item_d.sovf = 1'b1;
      end else begin
        item_d.sres = wide[ValW-1:0];
      end
    end else if ((op_i == OP_MOD || op_i == OP_DIV) && scalar_i != '0) begin
      item_d.special = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_q <= '0;
    end else if (en_i) begin
      item_q <= item_d;
    end
  end

  assign item_o = item_q;

endmodule

### dv/testbench.sv
module testbench;
  import sisa_pkg::*;

  typedef struct {
    logic [30:0] offset;
    logic [31:0] value;
    logic        keep;
    logic        ovf;
    logic        last;
  } elem_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = 1'b0;
  logic [31:0] cfg_data_i = '0;

  logic [OpW-1:0]  cur_op = OP_ADD;
  logic [ValW-1:0] cur_scalar = '0;
  elem_res_t       pending_q[$];
  int              mismatches = 0;
  bit              hold_rx = 1'b0;
  bit              rx_idle_en = 1'b1;

  sparse_int_scalar_arith u_dut (.*);

  always #5 clk_i = ~clk_i;

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Works out the result of one element under the current operation and scalar.
  function automatic elem_res_t arith_result(logic [30:0] off, logic [31:0] val, logic lst);
    elem_res_t       res;
    longint          x, y, r;
    logic [31:0]     v;
    res.offset = off;
    res.last = lst;
    res.ovf = 1'b0;
    x = longint'($signed(val));
    y = longint'($signed(cur_scalar));
    v = NaVal;
    if (val != NaVal && cur_scalar != NaVal) begin
      case (cur_op)
        OP_ADD, OP_SUB, OP_MUL: begin
          if (cur_op == OP_ADD) r = x + y;
          else if (cur_op == OP_SUB) r = x - y;
          else r = x * y;
          if (r <= -64'sd2147483648 || r > 64'sd2147483647) res.ovf = 1'b1;
          else v = r[31:0];
        end
        OP_MOD: begin
          if (y != 0) begin
            r = x % y;
            if ((y > 0 && r < 0) || (y < 0 && r > 0)) r = r + y;
            v = r[31:0];
          end
        end
        OP_DIV: begin
          if (y != 0) begin
            r = x / y;
            if (x % y != 0 && ((y > 0 && x < 0) || (y < 0 && x > 0))) r = r - 1;
            v = r[31:0];
          end
        end
        default: v = NaVal;
      endcase
    end
    res.value = v;
    res.keep = (v != 0);
    return res;
  endfunction

  // The item stays offered after its accepting edge until the next item, a gap or a drain replaces it.
  task automatic send_elem(logic [30:0] off, logic [31:0] val, logic lst, bit gaps = 1'b1);
    int unsigned g;
    g = gaps ? gap_len() : 0;
    if (g != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, val, off};
    s_axis_tlast <= lst;
    pending_q.push_back(arith_result(off, val, lst));
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [31:0] data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    if (idx == CfgIdxOp) cur_op = data[OpW-1:0];
    else cur_scalar = data;
  endtask

  task automatic set_mode(logic [OpW-1:0] op, logic [31:0] scl);
    wait_drained();
    write_cfg(CfgIdxOp, {29'd0, op});
    write_cfg(CfgIdxScl, scl);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 7))
      0: return NaVal;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0001;
      3: return $urandom_range(0, 20) - 10;
      4: return 32'd0;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_edges();
    logic [31:0] vals[10];
    vals = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0001,
             NaVal, 32'd7, 32'hFFFF_FFF9, 32'd6, 32'hFFFF_FFFA};
    for (int op = 0; op < 8; op++) begin
      set_mode(op[OpW-1:0], op[0] ? 32'hFFFF_FFFD : 32'd3);
      foreach (vals[i]) send_elem(i[0] ? 31'h7FFF_FFFF : 31'(i), vals[i], i == 9);
    end
    // Zero divisor, NA scalar and overflow of sub and mul.
    set_mode(OP_MOD, 32'd0);
    send_elem(31'd0, 32'd5, 1'b0);
    set_mode(OP_DIV, 32'd0);
    send_elem(31'd1, 32'd5, 1'b1);
    set_mode(OP_ADD, NaVal);
    send_elem(31'd2, 32'd5, 1'b0);
    set_mode(OP_SUB, 32'd1);
    send_elem(31'd3, 32'h8000_0001, 1'b1);
    set_mode(OP_MUL, 32'h7FFF_FFFF);
    send_elem(31'd4, 32'h7FFF_FFFF, 1'b0);
  endtask

  task automatic test_random();
    logic [31:0] scl;
    for (int ph = 0; ph < 12; ph++) begin
      case ($urandom_range(0, 4))
        0: scl = NaVal;
        1: scl = $urandom_range(0, 8) - 4;
        2: scl = 32'h7FFF_FFFF;
        default: scl = $urandom;
      endcase
      set_mode(3'($urandom_range(0, 7)), scl);
      repeat (45) send_elem(31'($urandom), rand_value(), $urandom_range(0, 9) == 0);
    end
  endtask

  // Receiver holds off long enough for the chain to fill and stall the input.
  task automatic test_backpressure();
    set_mode(OP_DIV, 32'hFFFF_FFF9);
    rx_idle_en = 1'b0;
    hold_rx = 1'b1;
    fork
      begin
        repeat (150) @(posedge clk_i);
        hold_rx = 1'b0;
      end
      repeat (60) send_elem(31'($urandom), $urandom, 1'($urandom_range(0, 1)), 1'b0);
    join
    rx_idle_en = 1'b1;
    wait_drained();
  endtask

  always @(posedge clk_i) begin
    if (hold_rx) m_axis_tready <= 1'b0;
    else if (!rx_idle_en) m_axis_tready <= 1'b1;
    else m_axis_tready <= ($urandom_range(0, 99) < 97) ? (gap_len() == 0 || $urandom_range(0, 1))
                                                       : 1'b0;
  end

  always @(posedge clk_i) begin
    elem_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item %h", m_axis_tdata);
      end else begin
        want = pending_q.pop_front();
        if (m_axis_tdata[30:0] !== want.offset || m_axis_tdata[62:31] !== want.value ||
            m_axis_tdata[63] !== want.keep || m_axis_tdata[64] !== want.ovf ||
            m_axis_tdata[71:65] !== 7'd0 || m_axis_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: op %0d scalar %h exp off %h val %h keep %b ovf %b",
                      " last %b, got tdata %h last %b"},
                     cur_op, cur_scalar, want.offset, want.value, want.keep, want.ovf,
                     want.last, m_axis_tdata, m_axis_tlast);
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_edges();
    test_backpressure();
    test_random();
    wait_drained();
    if (mismatches == 0 && pending_q.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
